### src/binary_fixed_to_decimal_ascii_macros.svh
// Assertion macros for the fixed-point to decimal text converter.
// Included by the top level; no other dependencies.
`ifndef BINARY_FIXED_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_FIXED_TO_DECIMAL_ASCII_MACROS_SVH
`ifndef SYNTHESIS
// Check a same-cycle implication.
`define BFDA_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("bfda assertion failed");
// Check an implication on the following cycle.
`define BFDA_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("bfda assertion failed");
`else
`define BFDA_ASSERT_NOW(lbl, clk, rst, pre, post)
`define BFDA_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

### src/bfda_pkg.sv
// Shared constants, types and codes of the fixed-point to decimal text converter.
// No dependencies.
package bfda_pkg;

   localparam int VALUE_W     = 32;
   localparam int CHAR_W      = 7;
   localparam int SCALED_W    = 17;
   localparam int RANGE_W     = 18;
   localparam int PROD_W      = 2 * SCALED_W;
   localparam int TEXT_LEN    = 6;
   localparam int IDX_W       = 3;
   localparam int STEP_W      = 3;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [VALUE_W-1:0]  LIMIT_VALUE = VALUE_W'(256000);
   localparam int                  FRAC_BITS   = 8;
   localparam logic [SCALED_W-1:0] DIV10_MULT  = SCALED_W'(104858);
   localparam int                  DIV10_SHIFT = 20;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] ASCII_BLANK = 7'h20;
   localparam logic [CHAR_W-1:0] ASCII_POINT = 7'h2E;
   localparam logic [CHAR_W-1:0] ASCII_STAR  = 7'h2A;

   // Text positions, first character at 0
   localparam logic [IDX_W-1:0] POS_HUNDREDS   = 3'd0;
   localparam logic [IDX_W-1:0] POS_TENS       = 3'd1;
   localparam logic [IDX_W-1:0] POS_ONES       = 3'd2;
   localparam logic [IDX_W-1:0] POS_POINT      = 3'd3;
   localparam logic [IDX_W-1:0] POS_TENTHS     = 3'd4;
   localparam logic [IDX_W-1:0] POS_HUNDREDTHS = 3'd5;
   localparam logic [IDX_W-1:0] POS_LAST       = 3'd5;

   // Digit steps, least significant first
   localparam logic [STEP_W-1:0] STEP_HUNDREDTHS = 3'd0;
   localparam logic [STEP_W-1:0] STEP_TENTHS     = 3'd1;
   localparam logic [STEP_W-1:0] STEP_ONES       = 3'd2;
   localparam logic [STEP_W-1:0] STEP_TENS       = 3'd3;
   localparam logic [STEP_W-1:0] STEP_HUNDREDS   = 3'd4;

   typedef logic [CHAR_W-1:0] char_type;
   typedef char_type [TEXT_LEN-1:0] text_type;

   // Classified item between front end and converter
   typedef struct packed {
      logic                err;
      logic [SCALED_W-1:0] scaled;
   } entry_type;

endpackage

### src/bfda_front.sv
// Front end: accepts values, checks range and scales to hundredths.
// Depends on bfda_pkg.
module bfda_front import bfda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               entry_valid,
   input  logic               entry_ready,
   output entry_type          entry_data
);

   logic             valid_ff, valid_in;
   entry_type        entry_ff, entry_in;
   logic             accept;
   logic [RANGE_W+6:0] prod;

   assign req_ready   = !valid_ff || entry_ready;
   assign accept      = req_valid && req_ready;
   assign entry_valid = valid_ff;
   assign entry_data  = entry_ff;

   // Classify and scale: times 100 as shifts, then drop the fraction bits
   always_comb begin
      prod = ({7'b0, req_value[RANGE_W-1:0]} << 6) + ({7'b0, req_value[RANGE_W-1:0]} << 5)
           + ({7'b0, req_value[RANGE_W-1:0]} << 2);
      entry_in.err    = (req_value >= LIMIT_VALUE);
      entry_in.scaled = prod[FRAC_BITS +: SCALED_W];
      valid_in        = accept || (valid_ff && !entry_ready);
   end

   // Hold the stage until the queue takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff <= entry_in;
      end
   end

endmodule

### src/bfda_fifo.sv
// Short queue between the front end and the digit converter.
// Depends on bfda_pkg.
module bfda_fifo import bfda_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      in_valid,
   output logic      in_ready,
   input  entry_type in_data,
   output logic      out_valid,
   input  logic      out_ready,
   output entry_type out_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = (count_ff != CNT_W'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Advance pointers with wrap at the depth
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

### src/bfda_digits.sv
// Digit converter: splits the scaled value one decimal digit a cycle into text.
// Depends on bfda_pkg.
module bfda_digits import bfda_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      entry_valid,
   output logic      entry_ready,
   input  entry_type entry_data,
   output logic      text_valid,
   input  logic      text_ready,
   output text_type  text
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [SCALED_W-1:0] rest_ff, rest_in;
   text_type            text_ff, text_in;
   logic                pop;
   logic [PROD_W-1:0]   prod;
   logic [SCALED_W-1:0] quot;
   logic [SCALED_W-1:0] remainder;
   char_type            digit_char;
   logic [IDX_W-1:0]    slot;

   assign text_valid  = (state_ff == ST_DONE);
   assign text        = text_ff;
   assign entry_ready = (state_ff == ST_IDLE) || (state_ff == ST_DONE && text_ready);
   assign pop         = entry_valid && entry_ready;

   // Divide by ten through the reciprocal, exact below 2**18
   always_comb begin
      prod      = {{SCALED_W{1'b0}}, rest_ff} * {{SCALED_W{1'b0}}, DIV10_MULT};
      quot      = SCALED_W'(prod >> DIV10_SHIFT);
      remainder = rest_ff - ((quot << 3) + (quot << 1));
      if (step_ff >= STEP_TENS && rest_ff == '0) begin
         digit_char = ASCII_BLANK;
      end else begin
         digit_char = ASCII_ZERO + {3'b0, remainder[3:0]};
      end
   end

   // Map the digit step to its text position
   always_comb begin
      unique case (step_ff)
         STEP_HUNDREDTHS: slot = POS_HUNDREDTHS;
         STEP_TENTHS:     slot = POS_TENTHS;
         STEP_ONES:       slot = POS_ONES;
         STEP_TENS:       slot = POS_TENS;
         STEP_HUNDREDS:   slot = POS_HUNDREDS;
         default:         slot = POS_HUNDREDS;
      endcase
   end

   // Sequence: load on pop, one digit a cycle, hold until handed off; out-of-range entries skip the digits
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      rest_in  = rest_ff;
      text_in  = text_ff;
      unique case (state_ff) inside
         ST_IDLE, ST_DONE: begin
            if (state_ff == ST_DONE && text_ready) begin
               state_in = ST_IDLE;
            end
            if (pop) begin
               step_in = STEP_HUNDREDTHS;
               rest_in = entry_data.scaled;
               if (entry_data.err) begin
                  text_in = {TEXT_LEN{ASCII_STAR}};
                  text_in[POS_POINT] = ASCII_POINT;
                  state_in = ST_DONE;
               end else begin
                  text_in[POS_POINT] = ASCII_POINT;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            text_in[slot] = digit_char;
            rest_in       = quot;
            step_in       = step_ff + 1'b1;
            if (step_ff == STEP_HUNDREDS) begin
               state_in = ST_DONE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      rest_ff <= rest_in;
      text_ff <= text_in;
   end

endmodule

### src/bfda_emit.sv
// Character emitter: sends the six-character text one word per cycle while rsp_ready is high.
// Depends on bfda_pkg.
module bfda_emit import bfda_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              text_valid,
   output logic              text_ready,
   input  text_type          text,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [CHAR_W-1:0] rsp_character,
   output logic              rsp_last_char
);

   logic             valid_ff, valid_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   text_type         text_ff;
   logic             send, load;

   assign rsp_valid     = valid_ff;
   assign rsp_character = text_ff[idx_ff];
   assign rsp_last_char = (idx_ff == POS_LAST);
   assign send          = valid_ff && rsp_ready;
   assign text_ready    = !valid_ff || (send && rsp_last_char);
   assign load          = text_valid && text_ready;

   // Advance through the text, reload on the last word
   always_comb begin
      valid_in = valid_ff;
      idx_in   = idx_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = '0;
      end else if (send) begin
         if (rsp_last_char) begin
            valid_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         text_ff <= text;
      end
   end

endmodule

### src/binary_fixed_to_decimal_ascii.sv
// Unsigned fixed-point (24.8, 32 bits) to six-character decimal text.
// Request channel req_valid/req_ready/req_value carries one 32-bit value per word;
// the value has 8 fraction bits.
// Response channel rsp_valid/rsp_ready carries one 7-bit ASCII character per word,
// six words per value, most significant first: hundreds, tens, ones, point,
// tenths, hundredths. Blank stands in the hundreds and tens places when nothing
// remains there. rsp_last_char marks the sixth word. Values of 1000.00 or more
// give "***.**".
// An accepted value passes the front register, the queue, the digit converter
// and the emitter register before its first character; an out-of-range value
// skips the digit steps. The response channel carries one character per cycle
// while rsp_ready is high; the digit converter works through a load and five
// digit steps per value and overlaps with the emitter.
// A front register and a two-entry queue decouple the request side, so
// requests keep being taken while the response side is stalled, until the queue
// and front register fill; then req_ready drops.
// Reset (synchronous, active high) empties all stages; nothing is pending after.
// Depends on bfda_pkg and binary_fixed_to_decimal_ascii_macros.svh.
`include "binary_fixed_to_decimal_ascii_macros.svh"
module binary_fixed_to_decimal_ascii import bfda_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [VALUE_W-1:0] req_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_character,
   output logic               rsp_last_char
);

   logic      front_valid, front_ready;
   entry_type front_data;
   logic      queue_valid, queue_ready;
   entry_type queue_data;
   logic      text_valid, text_ready;
   text_type  text;

   bfda_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .entry_valid (front_valid),
      .entry_ready (front_ready),
      .entry_data  (front_data)
   );

   bfda_fifo #(.DEPTH(DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_data)
   );

   bfda_digits u_digits (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (queue_valid),
      .entry_ready (queue_ready),
      .entry_data  (queue_data),
      .text_valid  (text_valid),
      .text_ready  (text_ready),
      .text        (text)
   );

   bfda_emit u_emit (
      .clock         (clock),
      .reset         (reset),
      .text_valid    (text_valid),
      .text_ready    (text_ready),
      .text          (text),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last_char (rsp_last_char)
   );

   // A text run never breaks before its last word
   `BFDA_ASSERT_NEXT(a_run_unbroken, clock, reset,
      rsp_valid && rsp_ready && !rsp_last_char, rsp_valid)
   // The final character is always a digit or a star, never blank
   `BFDA_ASSERT_NOW(a_last_not_blank, clock, reset,
      rsp_valid && rsp_last_char, rsp_character != ASCII_BLANK)
   // A classified entry refused by the queue is held, not dropped
   `BFDA_ASSERT_NEXT(a_front_holds, clock, reset,
      front_valid && !front_ready, front_valid)

endmodule
